// ===== hw/rtl/ffea_pkg.sv =====
// Package for the first-fit extent allocator: map geometry, field widths,
// command and status codes, and the map control bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffea_pkg;

	localparam int BLOCK_COUNT = 256;
	localparam int MAX_EXTENT  = 4;
	localparam int IDX_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 3;
	localparam int BIDX_W  = 8;
	localparam int STAT_W  = 3;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;
	// Spare code: ignored, answers ok.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_USED = 3'd4;

	// One access to the used map per cycle: the read always, plus set or clear.
	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             set;
		logic             clr;
	} map_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffea_map.sv =====
// Used/free bitmap of the extent allocator: a memory with one address per
// cycle, registered read data and a single-block set or clear. Uses ffea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffea_map (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffea_pkg::map_ctl_t ctl,
	output logic                    used
);
	import ffea_pkg::*;

	logic map_q [BLOCK_COUNT];
	logic used_q;

	// No reset on the array: the sequencer clears it after reset.
	always_ff @(posedge clk) begin
		if (ctl.set) begin
			map_q[ctl.addr] <= 1'b1;
		end else if (ctl.clr) begin
			map_q[ctl.addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			used_q <= map_q[ctl.addr];
		end
	end

	assign used = used_q;

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_extent_allocator.sv =====
// Top level of the first-fit extent allocator: command sequencer, scan
// counter and result register around the used map. Uses ffea_pkg, ffea_map.
//
//  channel  | handshake            | fields
//  ---------+----------------------+----------------------------------------
//  command  | start, busy          | command, extent_len, block_index
//  result   | done (strobe)        | status, start_block
//
// Unused code, rejected size, out-of-range free: result in the cycle after the transfer.
// Free: busy in ST_FREE while the map read returns, result registered as it leaves.
// Allocate: one block checked per cycle from block 0, then one marked per cycle; busy
//   while scanning and marking, result registered as the last block is marked or the scan ends.
// Format and reset: a clearing pass over all BLOCK_COUNT blocks (256) with busy high; only
//   format strobes a result at its end. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_extent_allocator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [ffea_pkg::CMD_W-1:0]   command,
	input  wire logic [ffea_pkg::SIZE_W-1:0]  extent_len,
	input  wire logic [ffea_pkg::BIDX_W-1:0]  block_index,
	output logic                              done,
	output logic [ffea_pkg::STAT_W-1:0]       status,
	output logic [ffea_pkg::BIDX_W-1:0]       start_block
);
	import ffea_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_MARK  = 5'b00100,
		ST_FREE  = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    scan_q;     // block under test, freed or cleared
	logic [SIZE_W-1:0]   run_q;      // free blocks seen in a row
	logic [SIZE_W-1:0]   size_q;     // requested extent
	logic [IDX_W-1:0]    mark_q;     // next block to mark used
	logic [SIZE_W-1:0]   left_q;     // blocks still to mark
	logic                fmt_q;      // clearing pass owes a result
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [BIDX_W-1:0]   start_q;

	map_ctl_t            map_ctl;
	logic                map_used;

	logic                accept;
	logic                size_bad;
	logic                idx_range_bad;
	logic [SIZE_W-1:0]   run_inc;
	logic                run_hit;
	logic [IDX_W-1:0]    fit_start;

	ffea_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (map_ctl),
		.used   (map_used)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign size_bad      = (extent_len == '0) ||
	                       ({29'd0, extent_len} > 32'(MAX_EXTENT));
	assign idx_range_bad = ({1'b0, block_index} >= (BIDX_W + 1)'(BLOCK_COUNT));

	// Scan unit: grow the free run, compare it with the request.
	// map_used holds the entry of scan_q while scanning.
	assign run_inc   = map_used ? '0 : run_q + SIZE_W'(1);
	assign run_hit   = !map_used && (run_inc == size_q);
	assign fit_start = scan_q - IDX_W'(size_q) + IDX_W'(1);

	// Map port: prime the read while idle, run one block ahead while scanning,
	// then clear the freed block, mark the extent or sweep the map.
	always_comb begin
		map_ctl = '0;
		case (state_q)
			ST_IDLE: begin
				map_ctl.addr = (command == CMD_ALLOC) ? '0 : block_index[IDX_W-1:0];
			end
			ST_SCAN: begin
				map_ctl.addr = scan_q + IDX_W'(1);
			end
			ST_FREE: begin
				map_ctl.addr = scan_q;
				map_ctl.clr  = map_used;
			end
			ST_MARK: begin
				map_ctl.addr = mark_q;
				map_ctl.set  = 1'b1;
			end
			ST_CLEAR: begin
				map_ctl.addr = scan_q;
				map_ctl.clr  = 1'b1;
			end
			default: begin
				map_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Sweep the map before the first transfer.
			state_q  <= ST_CLEAR;
			done_q   <= 1'b0;
			scan_q   <= '0;
			run_q    <= '0;
			size_q   <= '0;
			mark_q   <= '0;
			left_q   <= '0;
			fmt_q    <= 1'b0;
			status_q <= STAT_OK;
			start_q  <= '0;
		end else begin
			// The strobe lasts one cycle unless re-raised below.
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q <= '0;
						case (command)
							CMD_ALLOC: begin
								if (size_bad) begin
									status_q <= STAT_BAD_SIZE;
									done_q   <= 1'b1;
								end else begin
									size_q  <= extent_len;
									scan_q  <= '0;
									run_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							CMD_FREE: begin
								if (idx_range_bad) begin
									status_q <= STAT_RANGE;
									done_q   <= 1'b1;
								end else begin
									// Wait for the read of the named block.
									scan_q  <= block_index[IDX_W-1:0];
									state_q <= ST_FREE;
								end
							end
							CMD_FORMAT: begin
								scan_q  <= '0;
								fmt_q   <= 1'b1;
								state_q <= ST_CLEAR;
							end
							default: begin
								// The unused code: nothing to do.
								status_q <= STAT_OK;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					run_q <= run_inc;
					if (run_hit) begin
						mark_q  <= fit_start;
						left_q  <= size_q;
						start_q <= BIDX_W'(fit_start);
						state_q <= ST_MARK;
					end else if (scan_q == IDX_W'(BLOCK_COUNT - 1)) begin
						// Runs past the end of the map never fit.
						status_q <= STAT_NO_SPACE;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_FREE: begin
					status_q <= map_used ? STAT_OK : STAT_NOT_USED;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_MARK: begin
					mark_q <= mark_q + IDX_W'(1);
					left_q <= left_q - SIZE_W'(1);
					if (left_q == SIZE_W'(1)) begin
						status_q <= STAT_OK;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(BLOCK_COUNT - 1)) begin
						// Answer a format; drop the sweep after reset silently.
						status_q <= STAT_OK;
						done_q   <= fmt_q;
						fmt_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign start_block = start_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ffea_checker.sv =====
// Port-level checks for the first-fit extent allocator, bound to the top
// level. Uses ffea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffea_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [ffea_pkg::CMD_W-1:0]   command,
	input wire logic [ffea_pkg::SIZE_W-1:0]  extent_len,
	input wire logic [ffea_pkg::BIDX_W-1:0]  block_index,
	input wire logic                         done,
	input wire logic [ffea_pkg::STAT_W-1:0]  status,
	input wire logic [ffea_pkg::BIDX_W-1:0]  start_block
);
	import ffea_pkg::*;

	// A result only closes an item: the block is idle again as it strobes.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A result follows a transfer or a busy cycle, never from nowhere.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a command");

	// Only an allocate success carries a start block.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (start_block == '0))
		else $error("start block set on a failed command");

	// The unused code and a free beyond the map answer at once.
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_UNUSED ||
		 (command == CMD_FREE &&
		  {1'b0, block_index} >= (BIDX_W + 1)'(BLOCK_COUNT))))
		|=> (done && start_block == '0 &&
		     status == (($past(command) == CMD_UNUSED) ? STAT_OK : STAT_RANGE)))
		else $error("quick command did not answer");

	// A rejected size answers at once.
	a_bad_size: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_ALLOC &&
		 (extent_len == '0 || extent_len > SIZE_W'(MAX_EXTENT)))
		|=> (done && status == STAT_BAD_SIZE))
		else $error("bad size not reported");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (.*);

`default_nettype wire
